// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/slu_pkg.sv =====
// ----------------------------------------------------------------------------
// slu_pkg
// Shared types and codes of the string literal unescape core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slu_pkg;

  // decode modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_HEX1   = 3'd2;
  localparam logic [2:0] MODE_HEX2   = 3'd3;
  localparam logic [2:0] MODE_DEC2   = 3'd4;
  localparam logic [2:0] MODE_DEC3   = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_BADESC = 2'd2;
  localparam logic [1:0] KIND_EOF    = 2'd3;

  // output queue
  localparam int SLU_DEPTH = 4;
  localparam int SLU_PTR_W = $clog2(SLU_DEPTH);
  localparam int SLU_CNT_W = $clog2(SLU_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } slu_word_t;

  typedef struct packed {
    logic [2:0] mode_nxt;
    logic [7:0] val_nxt;
    logic [1:0] count;     // results caused by the word, 0..2
    slu_word_t  res0;
    slu_word_t  res1;
  } dec_out_t;

endpackage

// ===== rtl/core/string_literal_unescape_core.sv =====
// ----------------------------------------------------------------------------
// string_literal_unescape_core
// Streaming decoder for the body of a quoted string literal.
// ----------------------------------------------------------------------------
// Feed the bytes that follow the opening quote, one word per byte; a word with
// in_tuser set marks end of input and its data is ignored. Each input word is
// decoded in the cycle it is accepted and yields zero, one or two result
// words, which land in a four-entry output queue. The block takes one input
// word per clock as long as the queue has two free entries; the result side
// drains one word per clock while out_tready is high, so throughput is one
// input per cycle except where an early-terminated numeric escape produces
// two results and the queue can fill up.
// Results carry a kind code in out_tuser (data, string closed, unknown escape,
// unexpected end) and out_tlast marks the final result of each input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module string_literal_unescape_core (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] end_of_input
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] result_kind
  output logic       out_tlast   // last result of the input word
);
  import slu_pkg::*;

  localparam logic [SLU_PTR_W-1:0] PTR_ONE = SLU_PTR_W'(1);
  localparam logic [SLU_CNT_W-1:0] CNT_MAX = SLU_CNT_W'(SLU_DEPTH);
  localparam logic [SLU_CNT_W-1:0] CNT_LIM = SLU_CNT_W'(SLU_DEPTH - 2);

  // decode state
  logic [2:0] mode_r;
  logic [7:0] val_r;

  // output queue
  slu_word_t              q_mem [SLU_DEPTH];
  logic [SLU_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [SLU_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [SLU_CNT_W-1:0]   count_r, count_nxt;
  logic [SLU_PTR_W-1:0]   wr_ptr_p1;

  dec_out_t  dec;
  logic      in_acc;
  logic      out_acc;
  logic [1:0] push_n;
  slu_word_t head;

  slu_decoder u_dec (
    .in_byte      (in_tdata),
    .end_of_input (in_tuser),
    .mode         (mode_r),
    .val          (val_r),
    .dec          (dec)
  );

  // room for the worst case of two results
  assign in_tready = (count_r <= CNT_LIM);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign push_n    = in_acc ? dec.count : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + PTR_ONE;

  assign head       = q_mem[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = head.data;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + SLU_PTR_W'(push_n);
    rd_ptr_nxt = out_acc ? rd_ptr_r + PTR_ONE : rd_ptr_r;
    count_nxt  = count_r + SLU_CNT_W'(push_n) - SLU_CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      val_r    <= 8'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        mode_r <= dec.mode_nxt;
        val_r  <= dec.val_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_r] <= dec.res0;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr_p1] <= dec.res1;
    end
  end

  // queue never overfills
  `ASSERT_CLK(a_no_overflow, clk, rst_n, count_r <= CNT_MAX)
  // end of input always returns to plain text with a cleared value
  `ASSERT_CLK(a_eoi_resets, clk, rst_n,
              (in_acc && in_tuser) |=> (mode_r == MODE_NORMAL && val_r == 8'd0))
  // close and error results always end their input word
  `ASSERT_CLK(a_ctrl_last, clk, rst_n,
              (out_tvalid && out_tuser != KIND_DATA) |-> out_tlast)
  // queue is empty after a reset cycle
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (count_r == '0))

endmodule

// ===== rtl/core/slu_decoder.sv =====
// ----------------------------------------------------------------------------
// slu_decoder
// One-step escape decode: next mode, next value and up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slu_decoder (
  input  logic [7:0]        in_byte,
  input  logic              end_of_input,
  input  logic [2:0]        mode,
  input  logic [7:0]        val,
  output slu_pkg::dec_out_t dec
);
  import slu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_    = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CTL_BEL   = 8'h07;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_HT    = 8'h09;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_VT    = 8'h0B;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_CR    = 8'h0D;

  logic       is_dec;
  logic [7:0] dec_digit;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic       esc_known;
  logic [7:0] esc_val;
  logic [7:0] dec_acc;
  slu_word_t  nb_res;
  logic       nb_emit;

  assign is_dec    = (in_byte >= CH_0) && (in_byte <= CH_9);
  assign dec_digit = in_byte - CH_0;
  // val * 10 + digit, mod 256
  assign dec_acc   = {val[4:0], 3'b000} + {val[6:0], 1'b0} + dec_digit;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (is_dec) begin
      hex_val = dec_digit[3:0];
    end else if (in_byte >= CH_LA && in_byte <= CH_LF_) begin
      hex_val = 4'(in_byte - CH_LA + 8'd10);
    end else if (in_byte >= CH_UA && in_byte <= CH_UF) begin
      hex_val = 4'(in_byte - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_known = 1'b1;
    esc_val   = 8'd0;
    case (in_byte)
      CH_QUOTE:  esc_val = CH_QUOTE;
      CH_APOS:   esc_val = CH_APOS;
      CH_BSLASH: esc_val = CH_BSLASH;
      CH_LA:     esc_val = CTL_BEL;
      CH_B:      esc_val = CTL_BS;
      CH_LF_:    esc_val = CTL_FF;
      CH_N:      esc_val = CTL_LF;
      CH_R:      esc_val = CTL_CR;
      CH_T:      esc_val = CTL_HT;
      CH_V:      esc_val = CTL_VT;
      default:   esc_known = 1'b0;
    endcase
  end

  // plain-text handling of the byte: data, close, or nothing for a backslash
  always_comb begin
    nb_emit = (in_byte != CH_BSLASH);
    nb_res  = '{data: in_byte, kind: KIND_DATA, last: 1'b1};
    if (in_byte == CH_QUOTE) begin
      nb_res = '{data: 8'd0, kind: KIND_CLOSE, last: 1'b1};
    end
  end

  always_comb begin
    dec          = '0;
    dec.mode_nxt = mode;
    dec.val_nxt  = val;
    if (end_of_input) begin
      dec.count    = 2'd1;
      dec.res0     = '{data: 8'd0, kind: KIND_EOF, last: 1'b1};
      dec.mode_nxt = MODE_NORMAL;
      dec.val_nxt  = 8'd0;
    end else begin
      case (mode)
        MODE_ESC: begin
          dec.mode_nxt = MODE_NORMAL;
          if (esc_known) begin
            dec.count = 2'd1;
            dec.res0  = '{data: esc_val, kind: KIND_DATA, last: 1'b1};
          end else if (in_byte == CH_X) begin
            dec.mode_nxt = MODE_HEX1;
          end else if (is_dec) begin
            dec.val_nxt  = dec_digit;
            dec.mode_nxt = MODE_DEC2;
          end else begin
            dec.count   = 2'd1;
            dec.res0    = '{data: in_byte, kind: KIND_BADESC, last: 1'b1};
            dec.val_nxt = 8'd0;
          end
        end
        MODE_HEX1: begin
          if (hex_ok) begin
            dec.val_nxt  = {4'd0, hex_val};
            dec.mode_nxt = MODE_HEX2;
          end else begin
            dec.count    = 2'd1;
            dec.res0     = '{data: in_byte, kind: KIND_BADESC, last: 1'b1};
            dec.mode_nxt = MODE_NORMAL;
            dec.val_nxt  = 8'd0;
          end
        end
        MODE_HEX2, MODE_DEC2, MODE_DEC3: begin
          dec.mode_nxt = MODE_NORMAL;
          dec.val_nxt  = 8'd0;
          if (mode == MODE_HEX2 && hex_ok) begin
            dec.count = 2'd1;
            dec.res0  = '{data: {val[3:0], hex_val}, kind: KIND_DATA, last: 1'b1};
          end else if (mode == MODE_DEC2 && is_dec) begin
            dec.val_nxt  = dec_acc;
            dec.mode_nxt = MODE_DEC3;
          end else if (mode == MODE_DEC3 && is_dec) begin
            dec.count = 2'd1;
            dec.res0  = '{data: dec_acc, kind: KIND_DATA, last: 1'b1};
          end else begin
            // escape ended early: gathered byte, then the byte as plain text
            dec.res0 = '{data: val, kind: KIND_DATA, last: !nb_emit};
            if (nb_emit) begin
              dec.count = 2'd2;
              dec.res1  = nb_res;
            end else begin
              dec.count    = 2'd1;
              dec.mode_nxt = MODE_ESC;
            end
          end
        end
        default: begin
          dec.mode_nxt = MODE_NORMAL;
          if (nb_emit) begin
            dec.count = 2'd1;
            dec.res0  = nb_res;
            if (in_byte == CH_QUOTE) begin
              dec.val_nxt = 8'd0;
            end
          end else begin
            dec.mode_nxt = MODE_ESC;
          end
        end
      endcase
    end
  end

endmodule
